FILE: rtl/wpid_pkg.sv
// ----------------------------------------------------------------------------
// wpid_pkg
// Shared types and constants of the windowed PID motor drive.
// ----------------------------------------------------------------------------
package wpid_pkg;

  localparam int unsigned CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_PID_ENABLE    = 3'd3,
    REG_FORWARD_LEVEL = 3'd4
  } cfg_reg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the input item and the previous error
    logic acc_clear;  // clear the integral accumulator
    logic acc_step;   // add one ring product into the accumulator
    logic div_start;  // start the derivative divider
    logic div_step;   // one divider iteration
    logic finish;     // form effort and the result
  } wpid_cmd_t;

endpackage

FILE: rtl/wpid_datapath.sv
// ----------------------------------------------------------------------------
// wpid_datapath
// Error ring, multiply-accumulate of the integral, bit-serial divider of the
// derivative term and the effort to duty conversion.
// ----------------------------------------------------------------------------
module wpid_datapath #(
  parameter int WINDOW   = 10,
  parameter int PWM_BITS = 8
) (
  input  logic                  clk,
  input  wpid_pkg::wpid_cmd_t   cmd,
  input  logic [31:0]           target_pos,
  input  logic [31:0]           encoder_pos,
  input  logic [15:0]           elapsed_ms,
  input  logic signed [15:0]    gain_p,
  input  logic signed [15:0]    gain_i,
  input  logic signed [15:0]    gain_d,
  input  logic                  forward_level,
  input  logic [$clog2(WINDOW)-1:0] wr_pos,
  input  logic [$clog2(WINDOW)-1:0] rd_pos,
  input  logic [$clog2(WINDOW)-1:0] prev_pos,
  input  logic                  ring_we,
  input  logic                  ring_valid_rd,
  input  logic                  prev_valid,
  output logic                  dir_level,
  output logic [7:0]            duty
);
  import wpid_pkg::*;

  localparam logic [63:0] ITERM_LIMIT = 64'd1 << 60;
  localparam logic [63:0] DUTY_MAX = (64'd1 << PWM_BITS) - 64'd1;

  logic signed [31:0] err_ring [WINDOW];
  logic        [15:0] time_ring [WINDOW];

  logic signed [31:0] err;
  logic        [15:0] dt;
  logic signed [31:0] prev;
  logic signed [63:0] sum;
  logic signed [47:0] prod;
  logic signed [49:0] dnum;
  logic        [48:0] quo;
  logic        [48:0] dmag;
  logic        [16:0] rem;
  logic               dneg;

  logic [16:0] rem_sh;
  logic        rem_ge;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err  <= target_pos - encoder_pos;
      dt   <= elapsed_ms;
      prev <= prev_valid ? err_ring[prev_pos] : 32'sd0;
    end
    if (ring_we) begin
      err_ring[wr_pos]  <= err;
      time_ring[wr_pos] <= dt;
    end
  end

  // One product a cycle, registered before accumulation.
  always_ff @(posedge clk) begin
    prod <= ring_valid_rd ? $signed(err_ring[rd_pos]) * $signed({16'd0, time_ring[rd_pos]})
                          : 48'sd0;
    if (cmd.acc_clear) begin
      sum <= 64'sd0;
    end else if (cmd.acc_step) begin
      sum <= sum + 64'(prod);
    end
  end

  // Restoring divider on the magnitude of gain_d * (err - prev).
  assign rem_sh = {rem[15:0], dmag[48]};
  assign rem_ge = rem_sh >= {1'b0, dt};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dnum <= 50'(gain_d) * (50'(err) - 50'(prev));
      rem  <= '0;
      quo  <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? rem_sh - {1'b0, dt} : rem_sh;
      quo  <= {quo[47:0], rem_ge};
      dmag <= {dmag[47:0], 1'b0};
    end
    if (cmd.acc_step) begin
      dneg <= dnum[49];
      dmag <= dnum[49] ? 49'(-dnum) : dnum[48:0];
    end
  end

  // Saturated integral product, P and D terms and effort.
  logic [63:0]        smag;
  logic [15:0]        gmag;
  logic [79:0]        iprod;
  logic [63:0]        imag;
  logic signed [63:0] iterm;
  logic signed [63:0] pterm;
  logic signed [63:0] dterm;
  logic signed [63:0] effort;
  logic [63:0]        emag;
  logic [63:0]        shifted;

  always_comb begin
    smag  = sum[63] ? 64'(-sum) : 64'(sum);
    gmag  = gain_i[15] ? 16'(-gain_i) : 16'(gain_i);
    iprod = {16'd0, smag} * {64'd0, gmag};
    imag  = (iprod > {16'd0, ITERM_LIMIT}) ? ITERM_LIMIT : iprod[63:0];
    iterm = (gain_i[15] != sum[63]) ? -$signed(imag) : $signed(imag);
    pterm = 64'(48'(gain_p) * 48'(err));
    dterm = (dt == 16'd0) ? 64'sd0 : (dneg ? -$signed({15'd0, quo}) : $signed({15'd0, quo}));
    effort = pterm + iterm + dterm;
    emag   = effort[63] ? 64'(-effort) : 64'(effort);
    shifted = emag >> 8;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dir_level <= (effort > 64'sd0) ? forward_level : ~forward_level;
      duty      <= 8'((shifted > DUTY_MAX) ? DUTY_MAX : shifted);
    end
  end

endmodule

FILE: rtl/wpid_ctrl.sv
// ----------------------------------------------------------------------------
// wpid_ctrl
// Sequencer of one control tick: load, sum over the ring, divide, output.
// ----------------------------------------------------------------------------
module wpid_ctrl #(
  parameter int WINDOW = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_fire,
  input  logic                      out_taken,
  output logic                      busy,
  output logic                      out_valid,
  output wpid_pkg::wpid_cmd_t       cmd,
  output logic [$clog2(WINDOW)-1:0] wr_pos,
  output logic [$clog2(WINDOW)-1:0] rd_pos,
  output logic [$clog2(WINDOW)-1:0] prev_pos,
  output logic                      ring_we,
  output logic                      ring_valid_rd,
  output logic                      prev_valid
);
  import wpid_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_SUM, S_DRAIN, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t          state;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] idx;
  logic [5:0]       cnt;
  logic [WINDOW-1:0] written;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      idx     <= '0;
      cnt     <= '0;
      written <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) state <= S_WRITE;
        end
        S_WRITE: begin
          written[pos] <= 1'b1;
          idx   <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          if (idx == LAST) state <= S_DRAIN;
          else idx <= idx + 1'b1;
        end
        S_DRAIN: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == 6'd49) state <= S_FIN;
          cnt <= cnt + 1'b1;
        end
        S_FIN: begin
          pos   <= (pos == LAST) ? '0 : pos + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_taken) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = in_fire;
    cmd.div_start = (state == S_WRITE);
    cmd.acc_clear = (state == S_WRITE);
    cmd.acc_step  = (state == S_SUM && idx != '0) || state == S_DRAIN;
    cmd.div_step  = (state == S_DIV && cnt != 6'd0);
    cmd.finish    = (state == S_FIN);
  end

  assign busy          = (state != S_IDLE);
  assign out_valid     = (state == S_OUT);
  assign wr_pos        = pos;
  assign rd_pos        = idx;
  assign prev_pos      = (pos == '0) ? LAST : pos - 1'b1;
  assign ring_we       = (state == S_WRITE);
  assign ring_valid_rd = written[idx];
  assign prev_valid    = written[prev_pos];

  assert property (@(posedge clk) disable iff (rst) in_fire |=> state == S_WRITE)
    else $error("accepted item did not start a tick");
  assert property (@(posedge clk) disable iff (rst) state == S_FIN |=> out_valid)
    else $error("finished tick gave no result");
  assert property (@(posedge clk) disable iff (rst) ring_we |=> written[$past(pos)])
    else $error("ring entry not marked written");

endmodule

FILE: rtl/windowed_pid_motor_drive_core.sv
// ----------------------------------------------------------------------------
// windowed_pid_motor_drive_core
// Windowed PID position controller producing direction and PWM duty.
// ----------------------------------------------------------------------------
// A tick runs from input transfer to result with one cycle a ring entry for
// the error-time products, then the bit-serial divider for the derivative
// term. The next input is taken at the earliest in the cycle after the result
// transfer, so a new input is not taken while a tick or its result is pending.
// While pid_enable is low, input items are accepted and dropped with no
// result.
module windowed_pid_motor_drive_core #(
  parameter int WINDOW   = 10,
  parameter int PWM_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // target_pos, encoder_pos, elapsed_ms
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // dir_level, duty, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import wpid_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);

  logic signed [15:0] gain_p, gain_i, gain_d;
  logic pid_enable, forward_level;
  logic busy, in_fire, out_valid, ring_we, ring_valid_rd, prev_valid;
  logic dir_level;
  logic [7:0] duty;
  logic [IDX_W-1:0] wr_pos, rd_pos, prev_pos;
  wpid_cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0; gain_i <= '0; gain_d <= '0;
      pid_enable <= 1'b0; forward_level <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:        gain_p <= cfg_data;
        REG_GAIN_I:        gain_i <= cfg_data;
        REG_GAIN_D:        gain_d <= cfg_data;
        REG_PID_ENABLE:    pid_enable <= cfg_data[0];
        REG_FORWARD_LEVEL: forward_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && !busy && pid_enable;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, duty, dir_level};

  wpid_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk, .rst, .in_fire, .out_taken(m_axis_tready), .busy, .out_valid, .cmd,
    .wr_pos, .rd_pos, .prev_pos, .ring_we, .ring_valid_rd, .prev_valid
  );

  wpid_datapath #(.WINDOW(WINDOW), .PWM_BITS(PWM_BITS)) u_dp (
    .clk, .cmd,
    .target_pos(s_axis_tdata[31:0]), .encoder_pos(s_axis_tdata[63:32]),
    .elapsed_ms(s_axis_tdata[79:64]),
    .gain_p, .gain_i, .gain_d, .forward_level,
    .wr_pos, .rd_pos, .prev_pos, .ring_we, .ring_valid_rd, .prev_valid,
    .dir_level, .duty
  );

  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while a result is pending");
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst) !pid_enable && !busy |=> !m_axis_tvalid)
    else $error("result while loop disabled");

endmodule

FILE: test/windowed_pid_motor_drive_core_tb.sv
// ----------------------------------------------------------------------------
// windowed_pid_motor_drive_core_tb
// Self-checking bench: ticks are streamed in, each result is compared against
// an in-bench PID predictor, with random gaps on both sides and gain changes.
// ----------------------------------------------------------------------------
module windowed_pid_motor_drive_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wpid_pkg::*;

  typedef struct packed {
    logic [15:0] elapsed;
    logic [31:0] enc;
    logic [31:0] tgt;
  } tick_t;

  typedef struct packed {
    logic [6:0] fill;
    logic [7:0] duty;
    logic       dir;
  } drive_t;

  localparam int WINDOW = 10;
  localparam longint ILIMIT = 64'sd1 <<< 60;
  localparam int DOG_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  windowed_pid_motor_drive_core dut (.*);

  always #10 clk = ~clk;

  tick_t pending_ticks[$];
  drive_t expected_drive[$];
  int failures = 0;
  int dog = 0;
  int gap = 0;
  int stall = 0;
  int offered = 0;
  int accepted = 0;
  bit hold = 0;

  logic signed [15:0] kp = 0, ki = 0, kd = 0;
  bit enabled = 0, fwd = 1;
  logic signed [31:0] err_ring[WINDOW];
  logic [15:0] time_ring[WINDOW];
  int wpos = 0;

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 3);
  endfunction

  task automatic predict_drive(tick_t t);
    logic signed [31:0] e, prev;
    longint sum, p, i, d, eff, mag;
    longint unsigned g, s;
    drive_t r;
    if (!enabled) return;
    e = $signed(t.tgt) - $signed(t.enc);
    prev = err_ring[(wpos + WINDOW - 1) % WINDOW];
    err_ring[wpos] = e;
    time_ring[wpos] = t.elapsed;
    sum = 0;
    for (int k = 0; k < WINDOW; k++) sum += longint'(err_ring[k]) * longint'({1'b0, time_ring[k]});
    p = longint'(kp) * longint'(e);
    g = ki < 0 ? -longint'(ki) : longint'(ki);
    s = sum < 0 ? -sum : sum;
    if (g == 0 || s == 0) i = 0;
    else begin
      i = (s > ILIMIT / g) ? ILIMIT : longint'(s * g);
      if ((ki < 0) != (sum < 0)) i = -i;
    end
    if (t.elapsed == 0) d = 0;
    else d = (longint'(kd) * (longint'(e) - longint'(prev))) / longint'({1'b0, t.elapsed});
    eff = p + i + d;
    wpos = (wpos + 1) % WINDOW;
    mag = (eff < 0 ? -eff : eff) >>> 8;
    r = '0;
    r.dir = eff > 0 ? fwd : ~fwd;
    r.duty = mag > 255 ? 8'hFF : mag[7:0];
    expected_drive.push_back(r);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_GAIN_P: kp = val;
      REG_GAIN_I: ki = val;
      REG_GAIN_D: kd = val;
      REG_PID_ENABLE: enabled = val[0];
      REG_FORWARD_LEVEL: fwd = val[0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || s_axis_tvalid || expected_drive.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    int sel;
    sel = $urandom_range(0, 9);
    t.tgt = $urandom;
    t.enc = sel < 7 ? t.tgt + $signed($urandom_range(0, 4000)) - 2000 : $urandom;
    case ($urandom_range(0, 9))
      0: t.elapsed = 16'd0;
      1: t.elapsed = 16'($urandom);
      default: t.elapsed = 16'($urandom_range(1, 20));
    endcase
    return t;
  endfunction

  // Driver: one transfer per tick from the pending queue, and random stalls of the result ready.
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && accepted != offered) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        s_axis_tvalid <= 0;
      end else if (pending_ticks.size() != 0 && !(hold && expected_drive.size() != 0)) begin
        s_axis_tdata <= pending_ticks[0];
        s_axis_tvalid <= 1;
        offered <= offered + 1;
        gap <= pick_gap();
      end else
        s_axis_tvalid <= 0;
      if (stall > 0) begin
        stall <= stall - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
        stall <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_drive(tick_t'(s_axis_tdata));
      void'(pending_ticks.pop_front());
      accepted <= accepted + 1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_drive.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        failures++;
      end else begin
        drive_t x, a;
        x = expected_drive.pop_front();
        a = m_axis_tdata;
        if (a.dir !== x.dir) begin
          $display("%0t: dir_level expected %0d actual %0d", $time, x.dir, a.dir);
          failures++;
        end
        if (a.duty !== x.duty) begin
          $display("%0t: duty expected %0d actual %0d", $time, x.duty, a.duty);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      dog <= 0;
    else if (!rst) begin
      dog <= dog + 1;
      if (dog >= DOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic signed [15:0] gset[6][3] = '{
      '{16'sh0100, 16'sh0000, 16'sh0000}, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
      '{16'sh8000, 16'sh8000, 16'sh8000}, '{16'sh0040, 16'sh0001, 16'sh0200},
      '{16'shFF00, 16'shFFFE, 16'shFE00}, '{16'sh0000, 16'sh0000, 16'sh0000}};
    for (int k = 0; k < WINDOW; k++) begin
      err_ring[k] = 0;
      time_ring[k] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // Disabled: ticks are dropped.
    write_reg(REG_FORWARD_LEVEL, 16'h0001);
    for (int k = 0; k < 4; k++) pending_ticks.push_back(rand_tick());
    settle();
    write_reg(REG_GAIN_P, 16'h0100);
    write_reg(REG_GAIN_I, 16'h0001);
    write_reg(REG_GAIN_D, 16'h0100);
    write_reg(REG_PID_ENABLE, 16'hFFFF);
    // Directed: extremes, zero error, zero time, wrap of the error.
    pending_ticks.push_back('{16'd0, 32'd0, 32'd0});
    pending_ticks.push_back('{16'd0, 32'd5, 32'd1000});
    pending_ticks.push_back('{16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    pending_ticks.push_back('{16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    pending_ticks.push_back('{16'd1, 32'h0000_0001, 32'h0000_0000});
    pending_ticks.push_back('{16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF});
    pending_ticks.push_back('{16'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pending_ticks.push_back('{16'h8000, 32'h5555_5555, 32'hAAAA_AAAA});
    pending_ticks.push_back('{16'h7FFF, 32'hAAAA_AAAA, 32'h5555_5555});
    pending_ticks.push_back('{16'd2, 32'd100, 32'd100});
    settle();
    write_reg(REG_FORWARD_LEVEL, 16'h0000);
    for (int k = 0; k < 5; k++) pending_ticks.push_back(rand_tick());
    // The sender holds off until every result is in.
    hold = 1;
    settle();
    hold = 0;
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_GAIN_P, ph < 6 ? gset[ph][0] : 16'($urandom));
      write_reg(REG_GAIN_I, ph < 6 ? gset[ph][1] : 16'($urandom_range(0, 15)));
      write_reg(REG_GAIN_D, ph < 6 ? gset[ph][2] : 16'($urandom));
      write_reg(REG_FORWARD_LEVEL, 16'($urandom_range(0, 1)));
      write_reg(REG_PID_ENABLE, ph == 7 ? 16'h0000 : 16'h0001);
      for (int k = 0; k < 128; k++) pending_ticks.push_back(rand_tick());
      settle();
    end
    write_reg(cfg_reg_t'(3'd7), 16'h1234);
    if (failures == 0 && expected_drive.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
